@@ rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, types and helpers for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_W       = 64;
  localparam int OP_W         = 2;
  localparam int CNT_W        = 32;

  // configuration field widths
  localparam int SIB_W = 4;
  localparam int WIU_W = 4;
  localparam int OFF_W = 6;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SBE_W    = $clog2(MAX_SET_BITS + 1);
  localparam int SHAMT_W  = ((OFF_W > SBE_W) ? OFF_W : SBE_W) + 1;

  // APB register map
  localparam int NUM_REGS = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef enum logic [1:0] {
    REG_SET_INDEX_BITS    = 2'd0,
    REG_WAYS_IN_USE       = 2'd1,
    REG_BLOCK_OFFSET_BITS = 2'd2,
    REG_UNUSED            = 2'd3
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [SIB_W-1:0] set_index_bits;
    logic [WIU_W-1:0] ways_in_use;
    logic [OFF_W-1:0] block_offset_bits;
  } cfg_t;

  // one set: all ways side by side
  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]    tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
  } row_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } lk_flags_t;

  // state of a set after reset: nothing valid, rank equals way index
  function automatic row_t clear_row();
    row_t r;
    r = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      r.rank[w] = RANK_W'(w);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] cnt, logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

@@ rtl/salc_if.sv @@
// ----------------------------------------------------------------------------
// salc_if
// Valid/ready channels for access requests and lookup responses.
// ----------------------------------------------------------------------------
interface salc_req_if;
  logic                        valid;
  logic                        ready;
  logic [salc_pkg::OP_W-1:0]   opcode;
  logic [salc_pkg::ADDR_W-1:0] address;

  modport source (output valid, opcode, address, input ready);
  modport sink   (input valid, opcode, address, output ready);
endinterface

interface salc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       was_hit;
  logic                       was_miss;
  logic                       was_evict;
  logic [salc_pkg::CNT_W-1:0] hit_total;
  logic [salc_pkg::CNT_W-1:0] miss_total;
  logic [salc_pkg::CNT_W-1:0] evict_total;

  modport source (output valid, was_hit, was_miss, was_evict, hit_total, miss_total,
                  evict_total, input ready);
  modport sink   (input valid, was_hit, was_miss, was_evict, hit_total, miss_total,
                  evict_total, output ready);
endinterface

@@ rtl/salc_cfg.sv @@
// ----------------------------------------------------------------------------
// salc_cfg
// APB configuration registers: set index width, ways in use, offset width.
// ----------------------------------------------------------------------------
module salc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]  paddr,
  input  logic [salc_pkg::PDATA_W-1:0]  pwdata,
  output logic [salc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output salc_pkg::cfg_t                cfg
);

  salc_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = salc_pkg::reg_idx_t'(paddr[salc_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_index_bits    <= salc_pkg::SIB_W'(4);
      cfg.ways_in_use       <= salc_pkg::WIU_W'(1);
      cfg.block_offset_bits <= salc_pkg::OFF_W'(4);
    end else if (wr) begin
      case (idx)
        salc_pkg::REG_SET_INDEX_BITS:
          cfg.set_index_bits <= pwdata[salc_pkg::SIB_W-1:0];
        salc_pkg::REG_WAYS_IN_USE:
          cfg.ways_in_use <= pwdata[salc_pkg::WIU_W-1:0];
        salc_pkg::REG_BLOCK_OFFSET_BITS:
          cfg.block_offset_bits <= pwdata[salc_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      salc_pkg::REG_SET_INDEX_BITS:
        prdata = salc_pkg::PDATA_W'(cfg.set_index_bits);
      salc_pkg::REG_WAYS_IN_USE:
        prdata = salc_pkg::PDATA_W'(cfg.ways_in_use);
      salc_pkg::REG_BLOCK_OFFSET_BITS:
        prdata = salc_pkg::PDATA_W'(cfg.block_offset_bits);
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ rtl/salc_split.sv @@
// ----------------------------------------------------------------------------
// salc_split
// Address split into set index and tag under the configured field widths.
// ----------------------------------------------------------------------------
module salc_split (
  input  logic [salc_pkg::ADDR_W-1:0] address,
  input  salc_pkg::cfg_t              cfg,
  output logic [salc_pkg::SET_W-1:0]  set_idx,
  output logic [salc_pkg::ADDR_W-1:0] tag
);

  logic [salc_pkg::SBE_W-1:0]   sbits;
  logic [salc_pkg::SHAMT_W-1:0] tag_sh;
  logic [salc_pkg::ADDR_W-1:0]  off_sh;
  logic [salc_pkg::ADDR_W-1:0]  set_mask;

  always_comb begin
    if (int'(cfg.set_index_bits) > salc_pkg::MAX_SET_BITS) begin
      sbits = salc_pkg::SBE_W'(salc_pkg::MAX_SET_BITS);
    end else begin
      sbits = salc_pkg::SBE_W'(cfg.set_index_bits);
    end

    if (int'(cfg.block_offset_bits) >= salc_pkg::ADDR_W) begin
      off_sh = '0;
    end else begin
      off_sh = address >> cfg.block_offset_bits;
    end
    set_mask = (salc_pkg::ADDR_W'(1) << sbits) - salc_pkg::ADDR_W'(1);
    set_idx  = salc_pkg::SET_W'(off_sh & set_mask);

    // tag is whatever lies above offset and set; nothing left reads as zero
    tag_sh = salc_pkg::SHAMT_W'(cfg.block_offset_bits) + salc_pkg::SHAMT_W'(sbits);
    if (int'(tag_sh) >= salc_pkg::ADDR_W) begin
      tag = '0;
    end else begin
      tag = address >> tag_sh;
    end
  end

endmodule

@@ rtl/salc_tag_store.sv @@
// ----------------------------------------------------------------------------
// salc_tag_store
// Row memory, one row per set, with registered read, write-back bypass and
// a clearing sweep after reset.
// ----------------------------------------------------------------------------
module salc_tag_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [salc_pkg::SET_W-1:0]  rd_set,
  input  logic [salc_pkg::SET_W-1:0]  cur_set,
  input  logic                        wr_en,
  input  logic [salc_pkg::SET_W-1:0]  wr_set,
  input  salc_pkg::row_t              wr_row,
  output salc_pkg::row_t              cur_row,
  output logic                        clr_busy
);

  salc_pkg::row_t             mem [salc_pkg::NUM_SETS];
  salc_pkg::row_t             rd_q;
  salc_pkg::row_t             wb_row;
  logic [salc_pkg::SET_W-1:0] wb_set;
  logic                       wb_valid;
  logic [salc_pkg::SET_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx] <= salc_pkg::clear_row();
    end else if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == salc_pkg::SET_W'(salc_pkg::NUM_SETS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // keep the last written row; it always matches the memory for its set
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_row <= wr_row;
      wb_set <= wr_set;
    end
  end

  // read and write of one set at the same edge returns stale data: bypass
  assign cur_row = (wb_valid && wb_set == cur_set) ? wb_row : rd_q;

endmodule

@@ rtl/salc_lookup.sv @@
// ----------------------------------------------------------------------------
// salc_lookup
// Parallel tag compare over one set, victim choice and LRU rank update.
// ----------------------------------------------------------------------------
module salc_lookup (
  input  salc_pkg::row_t              row,
  input  logic [salc_pkg::ADDR_W-1:0] tag,
  input  logic [salc_pkg::WIU_W-1:0]  ways_in_use,
  output salc_pkg::row_t              new_row,
  output salc_pkg::lk_flags_t         flags
);

  logic [salc_pkg::WCNT_W-1:0]   ways;
  logic [salc_pkg::MAX_WAYS-1:0] in_use;
  logic [salc_pkg::MAX_WAYS-1:0] match;
  logic [salc_pkg::MAX_WAYS-1:0] empty;
  logic [salc_pkg::RANK_W-1:0]   hit_way;
  logic [salc_pkg::RANK_W-1:0]   empty_way;
  logic [salc_pkg::RANK_W-1:0]   lru_way;
  logic [salc_pkg::RANK_W-1:0]   oldest;
  logic [salc_pkg::RANK_W-1:0]   chosen;
  logic [salc_pkg::RANK_W-1:0]   old_rank;
  logic                          any_hit;
  logic                          any_empty;

  always_comb begin
    if (ways_in_use == '0) begin
      ways = salc_pkg::WCNT_W'(1);
    end else if (int'(ways_in_use) > salc_pkg::MAX_WAYS) begin
      ways = salc_pkg::WCNT_W'(salc_pkg::MAX_WAYS);
    end else begin
      ways = salc_pkg::WCNT_W'(ways_in_use);
    end

    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      in_use[w] = (w < int'(ways));
      match[w]  = in_use[w] && row.valid[w] && (row.tag[w] == tag);
      empty[w]  = in_use[w] && !row.valid[w];
    end
    any_hit   = |match;
    any_empty = |empty;

    // lowest-numbered matching and lowest-numbered free way
    hit_way   = '0;
    empty_way = '0;
    for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = salc_pkg::RANK_W'(w);
      end
      if (empty[w]) begin
        empty_way = salc_pkg::RANK_W'(w);
      end
    end

    oldest  = '0;
    lru_way = '0;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      if (in_use[w] && row.rank[w] >= oldest) begin
        oldest  = row.rank[w];
        lru_way = salc_pkg::RANK_W'(w);
      end
    end

    if (any_hit) begin
      chosen = hit_way;
    end else if (any_empty) begin
      chosen = empty_way;
    end else begin
      chosen = lru_way;
    end

    new_row = row;
    if (!any_hit) begin
      new_row.valid[chosen] = 1'b1;
      new_row.tag[chosen]   = tag;
    end

    // touched way goes to rank zero, younger ways age by one
    old_rank = row.rank[chosen];
    for (int k = 0; k < salc_pkg::MAX_WAYS; k++) begin
      if (row.rank[k] < old_rank) begin
        new_row.rank[k] = row.rank[k] + 1'b1;
      end
    end
    new_row.rank[chosen] = '0;

    flags.hit   = any_hit;
    flags.miss  = !any_hit;
    flags.evict = !any_hit && !any_empty;
  end

endmodule

@@ rtl/set_assoc_lru_cache_tags_core.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_core
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Takes one access per cycle while rsp is not stalled and returns one result
// per access: the input register stage reads the set's row (all ways, tags,
// valid bits and LRU ranks) from the row memory, the lookup stage compares all
// ways at once, writes the updated row back and loads the result register.
// Back-to-back accesses to the same set are bypassed from the last written
// row, so the memory's single read and write port sets the rate of one per
// cycle. After reset the block clears the row memory in a sweep over all 256
// sets (one set per cycle) and holds req.ready low meanwhile; register writes
// are taken during the sweep. Configure only while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_core (
  input  logic                          clk,
  input  logic                          rst,
  salc_req_if.sink                      req,
  salc_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]  paddr,
  input  logic [salc_pkg::PDATA_W-1:0]  pwdata,
  output logic [salc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  salc_pkg::cfg_t              cfg;

  // input register
  logic                        s1_valid;
  logic [salc_pkg::OP_W-1:0]   s1_op;
  logic [salc_pkg::ADDR_W-1:0] s1_addr;
  logic [salc_pkg::SET_W-1:0]  s1_set;
  logic [salc_pkg::ADDR_W-1:0] s1_tag;

  // lookup stage
  logic                        s2_valid;
  logic [salc_pkg::OP_W-1:0]   s2_op;
  logic [salc_pkg::SET_W-1:0]  s2_set;
  logic [salc_pkg::ADDR_W-1:0] s2_tag;

  // totals and result register
  logic [salc_pkg::CNT_W-1:0]  hit_sum;
  logic [salc_pkg::CNT_W-1:0]  miss_sum;
  logic [salc_pkg::CNT_W-1:0]  evict_sum;
  logic [salc_pkg::CNT_W-1:0]  hit_sum_next;
  logic [salc_pkg::CNT_W-1:0]  miss_sum_next;
  logic [salc_pkg::CNT_W-1:0]  evict_sum_next;
  logic                        out_valid;
  salc_pkg::lk_flags_t         out_flags;

  salc_pkg::row_t              cur_row;
  salc_pkg::row_t              new_row;
  salc_pkg::lk_flags_t         flags;
  logic                        clr_busy;
  logic [1:0]                  hit_inc;

  logic out_free, s2_move, s2_free, s1_move, s1_free, in_fire;

  assign out_free  = !out_valid || rsp.ready;
  assign s2_move   = s2_valid && out_free;
  assign s2_free   = !s2_valid || out_free;
  assign s1_move   = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_free;
  assign req.ready = s1_free && !clr_busy;
  assign in_fire   = req.valid && req.ready;

  salc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  salc_split u_split (
    .address (s1_addr),
    .cfg     (cfg),
    .set_idx (s1_set),
    .tag     (s1_tag)
  );

  salc_tag_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s1_move),
    .rd_set   (s1_set),
    .cur_set  (s2_set),
    .wr_en    (s2_move),
    .wr_set   (s2_set),
    .wr_row   (new_row),
    .cur_row  (cur_row),
    .clr_busy (clr_busy)
  );

  salc_lookup u_lookup (
    .row         (cur_row),
    .tag         (s2_tag),
    .ways_in_use (cfg.ways_in_use),
    .new_row     (new_row),
    .flags       (flags)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      hit_sum   <= '0;
      miss_sum  <= '0;
      evict_sum <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        out_valid <= 1'b1;
        hit_sum   <= hit_sum_next;
        miss_sum  <= miss_sum_next;
        evict_sum <= evict_sum_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op   <= req.opcode;
      s1_addr <= req.address;
    end
    if (s1_move) begin
      s2_op  <= s1_op;
      s2_set <= s1_set;
      s2_tag <= s1_tag;
    end
    if (s2_move) begin
      out_flags <= flags;
    end
  end

  // a modify's second access always hits
  always_comb begin
    hit_inc = {1'b0, flags.hit}
            + {1'b0, s2_op == salc_pkg::OP_W'(salc_pkg::OP_MODIFY)};
    hit_sum_next   = salc_pkg::sat_add(hit_sum, hit_inc);
    miss_sum_next  = salc_pkg::sat_add(miss_sum, {1'b0, flags.miss});
    evict_sum_next = salc_pkg::sat_add(evict_sum, {1'b0, flags.evict});
  end

  assign rsp.valid       = out_valid;
  assign rsp.was_hit     = out_flags.hit;
  assign rsp.was_miss    = out_flags.miss;
  assign rsp.was_evict   = out_flags.evict;
  assign rsp.hit_total   = hit_sum;
  assign rsp.miss_total  = miss_sum;
  assign rsp.evict_total = evict_sum;

endmodule

@@ rtl/salc_checker.sv @@
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the tag store's request and response channels.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_was_hit,
  input logic                       rsp_was_miss,
  input logic                       rsp_was_evict,
  input logic [salc_pkg::CNT_W-1:0] rsp_hit_total,
  input logic [salc_pkg::CNT_W-1:0] rsp_miss_total,
  input logic [salc_pkg::CNT_W-1:0] rsp_evict_total
);

  // no request transfer while the clearing sweep starts
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken right after reset");

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_was_hit ^ rsp_was_miss))
    else $error("result is not exactly one of hit and miss");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_was_evict) |-> rsp_was_miss)
    else $error("eviction reported without a miss");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response dropped before transfer");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      ($stable(rsp_was_hit) && $stable(rsp_was_miss) && $stable(rsp_was_evict) &&
       $stable(rsp_hit_total) && $stable(rsp_miss_total) && $stable(rsp_evict_total)))
    else $error("stalled response changed");

endmodule

bind set_assoc_lru_cache_tags_core salc_checker u_salc_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_was_hit     (rsp.was_hit),
  .rsp_was_miss    (rsp.was_miss),
  .rsp_was_evict   (rsp.was_evict),
  .rsp_hit_total   (rsp.hit_total),
  .rsp_miss_total  (rsp.miss_total),
  .rsp_evict_total (rsp.evict_total)
);
